### sv/utf8cdw_pkg.sv
// Package for the UTF-8 character display writer.
// Holds beat and config types, code constants, the two-byte symbol table
// and the cursor split tables. No dependencies.
package utf8cdw_pkg;

    // Display geometry
    localparam int DIGITS_PER_DISPLAY = 8;   // 1 .. 16
    localparam int TOTAL_DIGITS       = 32;  // 1 .. 63

    localparam int CURSOR_W = 6;
    localparam int CURSOR_N = 1 << CURSOR_W;

    // Input mode codes
    localparam logic MODE_TEXT   = 1'b0;
    localparam logic MODE_CURSOR = 1'b1;

    // UTF-8 lead bytes that open a table lookup
    localparam logic [7:0] LEAD_LATIN1 = 8'hC2;
    localparam logic [7:0] LEAD_UMLAUT = 8'hC3;
    localparam logic [7:0] LEAD_GREEK  = 8'hCE;

    // Register indexes on the config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ASCII_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_RAM_BASE = 2'd2;
    localparam int CFG_DATA_W = 8;

    // Reset values of the config registers
    localparam logic [7:0] ASCII_LIMIT_RST   = 8'd128;
    localparam logic [7:0] GLYPH_LIMIT_RST   = 8'd144;
    localparam logic [4:0] CHAR_RAM_BASE_RST = 5'd24;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_in;
        logic [5:0] position;
    } char_beat_t;

    typedef struct packed {
        logic [1:0] display_index;
        logic [4:0] ram_address;
        logic [7:0] char_code;
    } wr_beat_t;

    typedef struct packed {
        logic [7:0] ascii_limit;
        logic [7:0] glyph_limit;
        logic [4:0] char_ram_base;
    } cfg_t;

    // Decode results handed back to the state registers
    typedef struct packed {
        logic                hit;
        logic [7:0]          pending_next;
        logic [CURSOR_W-1:0] cursor_next;
        wr_beat_t            beat;
    } dec_t;

    // Two-byte UTF-8 symbol lookup; zero means no match
    function automatic logic [7:0] lookup_pair(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] code;
        code = 8'h00;
        case (lead)
            LEAD_LATIN1:
            begin
                case (b)
                    8'hB2:   code = 8'h1D;
                    8'hB5:   code = 8'h0C;
                    8'hA3:   code = 8'h1E;
                    8'hA5:   code = 8'h1F;
                    default: code = 8'h00;
                endcase
            end
            LEAD_UMLAUT:
            begin
                case (b)
                    8'h9F:   code = 8'h06;
                    8'h85:   code = 8'h13;
                    8'hA5:   code = 8'h14;
                    8'h84:   code = 8'h15;
                    8'hA4:   code = 8'h16;
                    8'h96:   code = 8'h17;
                    8'hB6:   code = 8'h18;
                    8'h9C:   code = 8'h19;
                    8'hBC:   code = 8'h1A;
                    default: code = 8'h00;
                endcase
            end
            LEAD_GREEK:
            begin
                case (b)
                    8'hB1:   code = 8'h05;
                    8'hB2:   code = 8'h06;
                    8'hB4:   code = 8'h07;
                    8'h94:   code = 8'h08;
                    8'hB7:   code = 8'h09;
                    8'hB8:   code = 8'h0A;
                    8'hBB:   code = 8'h0B;
                    8'hBC:   code = 8'h0C;
                    8'h80:   code = 8'h0D;
                    8'h83:   code = 8'h0E;
                    8'hA3:   code = 8'h0F;
                    8'h84:   code = 8'h10;
                    8'hA6:   code = 8'h11;
                    8'hA9:   code = 8'h12;
                    8'h93:   code = 8'h1C;
                    default: code = 8'h00;
                endcase
            end
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Cursor split into display and digit, built by counting at elaboration
    function automatic logic [CURSOR_N-1:0][CURSOR_W-1:0] split_table(
        input logic [CURSOR_W-1:0] divisor,
        input logic                want_rem
    );
        logic [CURSOR_N-1:0][CURSOR_W-1:0] tab;
        logic [CURSOR_W-1:0] q;
        logic [CURSOR_W-1:0] r;
        q = '0;
        r = '0;
        for (int i = 0; i < CURSOR_N; i++)
        begin
            tab[i] = want_rem ? r : q;
            r = r + 1'b1;
            if (r == divisor)
            begin
                r = '0;
                q = q + 1'b1;
            end
        end
        return tab;
    endfunction

    localparam logic [CURSOR_W-1:0] DPD_W = CURSOR_W'(DIGITS_PER_DISPLAY);
    localparam logic [CURSOR_N-1:0][CURSOR_W-1:0] QUOT_TAB = split_table(DPD_W, 1'b0);
    localparam logic [CURSOR_N-1:0][CURSOR_W-1:0] REM_TAB  = split_table(DPD_W, 1'b1);
    localparam logic [CURSOR_W-1:0] LAST_LIMIT = CURSOR_W'(TOTAL_DIGITS);

endpackage

### sv/utf8cdw_in_stage.sv
// Input register stage for the character channel.
// Holds one beat until the decode stage takes it. Uses utf8cdw_pkg.
module utf8cdw_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  utf8cdw_pkg::char_beat_t char_beat,
    input  logic                    sink_free,
    output logic                    held_valid,
    output utf8cdw_pkg::char_beat_t held_beat
);
    import utf8cdw_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_beat_t beat_reg;
    logic       accept;
    logic       advance;

    // Stall only while a held beat cannot move on
    assign char_stall = valid_reg && !sink_free;
    assign accept     = char_valid && !char_stall;
    assign advance    = valid_reg && sink_free;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            beat_reg <= char_beat;
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

### sv/utf8cdw_decode.sv
// Combinational decode of one held beat against pending byte and cursor.
// Pass-through test, symbol lookup and cursor update. Uses utf8cdw_pkg.
module utf8cdw_decode (
    input  utf8cdw_pkg::char_beat_t beat,
    input  utf8cdw_pkg::cfg_t       cfg,
    input  logic [7:0]              pending,
    input  logic [5:0]              cursor,
    output utf8cdw_pkg::dec_t       dec
);
    import utf8cdw_pkg::*;

    logic       pass;
    logic [7:0] code;
    logic       in_range;
    logic [CURSOR_W-1:0] quot;
    logic [CURSOR_W-1:0] rem;

    // Pass straight through below the limits, otherwise look up the pair
    assign pass = (beat.byte_in < cfg.ascii_limit)
               || ((pending == 8'h00) && (beat.byte_in < cfg.glyph_limit));
    assign code = pass ? beat.byte_in : lookup_pair(pending, beat.byte_in);

    assign in_range = cursor < LAST_LIMIT;
    assign quot     = QUOT_TAB[cursor];
    assign rem      = REM_TAB[cursor];

    always_comb
    begin
        dec                    = '0;
        dec.beat.display_index = quot[1:0];
        dec.beat.ram_address   = cfg.char_ram_base | rem[4:0];
        dec.beat.char_code     = code;
        case (beat.mode)
            MODE_CURSOR:
            begin
                dec.hit          = 1'b0;
                dec.pending_next = pending;
                dec.cursor_next  = beat.position;
            end
            default:
            begin
                dec.hit          = (code != 8'h00) && in_range;
                dec.pending_next = pass ? 8'h00 : beat.byte_in;
                dec.cursor_next  = dec.hit ? cursor + 1'b1 : cursor;
            end
        endcase
    end

endmodule

### sv/utf8_char_display_writer_top.sv
// Top level of the UTF-8 character display writer.
// Uses utf8cdw_pkg, utf8cdw_in_stage and utf8cdw_decode.
//
//  channel  | direction | handshake              | payload
//  char     | in        | char_valid/char_stall  | char_beat (mode, byte_in, position)
//  wr       | out       | wr_valid/wr_stall      | wr_beat (display_index, ram_address, char_code)
//  cfg      | in        | cfg_en                 | cfg_index, cfg_data
//
// One beat per cycle sustained while wr_stall is low; an accepted beat waits in the input
// register and its result is offered from the result register. The rate is set by the
// single decode pass between the input and result registers. wr_stall holds the result
// register; char_stall rises only while both registers are full and wr_stall is high.
// Reset clears the pending byte and cursor and loads the config reset values.
module utf8_char_display_writer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_stall,
    input  utf8cdw_pkg::char_beat_t             char_beat,
    output logic                                wr_valid,
    input  logic                                wr_stall,
    output utf8cdw_pkg::wr_beat_t               wr_beat,
    input  logic                                cfg_en,
    input  logic [utf8cdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [utf8cdw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import utf8cdw_pkg::*;

    cfg_t                cfg_reg;
    logic [7:0]          pending_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic                wr_valid_reg;
    logic                wr_valid_next;
    wr_beat_t            wr_beat_reg;
    logic                sink_free;
    logic                held_valid;
    char_beat_t          held_beat;
    logic                advance;
    dec_t                dec;

    assign sink_free = !wr_valid_reg || !wr_stall;
    assign advance   = held_valid && sink_free;

    utf8cdw_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .sink_free  (sink_free),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    utf8cdw_decode u_dec (
        .beat    (held_beat),
        .cfg     (cfg_reg),
        .pending (pending_reg),
        .cursor  (cursor_reg),
        .dec     (dec)
    );

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ascii_limit   <= ASCII_LIMIT_RST;
            cfg_reg.glyph_limit   <= GLYPH_LIMIT_RST;
            cfg_reg.char_ram_base <= CHAR_RAM_BASE_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_ASCII_LIMIT:   cfg_reg.ascii_limit   <= cfg_data;
                CFG_GLYPH_LIMIT:   cfg_reg.glyph_limit   <= cfg_data;
                CFG_CHAR_RAM_BASE: cfg_reg.char_ram_base <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // Pending byte and cursor move when a beat is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 8'h00;
            cursor_reg  <= '0;
        end
        else if (advance)
        begin
            pending_reg <= dec.pending_next;
            cursor_reg  <= dec.cursor_next;
        end
    end

    // Result register valid
    always_comb
    begin
        if (advance)
            wr_valid_next = dec.hit;
        else
            wr_valid_next = wr_valid_reg && wr_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else
            wr_valid_reg <= wr_valid_next;
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance && dec.hit)
            wr_beat_reg <= dec.beat;
    end

    assign wr_valid = wr_valid_reg;
    assign wr_beat  = wr_beat_reg;

endmodule

### sv/utf8cdw_checker.sv
// Port-level checker for the UTF-8 character display writer, with its bind.
// Uses utf8cdw_pkg; attaches to utf8_char_display_writer_top.
module utf8cdw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                char_stall,
    input logic                                wr_valid,
    input logic                                wr_stall,
    input utf8cdw_pkg::wr_beat_t               wr_beat
);
    import utf8cdw_pkg::*;

    // A stalled result stays offered
    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_stall |=> wr_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_wr_stable: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_stall |=> $stable(wr_beat))
        else $error("result payload changed while stalled");

    // Zero codes are never written
    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> wr_beat.char_code != 8'h00)
        else $error("zero character code written");

    // Input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> wr_valid && wr_stall)
        else $error("input stalled with result side free");

endmodule

bind utf8_char_display_writer_top utf8cdw_checker u_chk (.*);
